@@ rtl/assert_macros.svh @@
// Assertion macros shared by the directory RTL.
// Each macro expects aclk and aresetn in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock, held off during reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lscd_pkg.sv @@
// Shared types and constants of the LRU slot cache directory.
// No dependencies; used by lscd_ctrl, lscd_datapath and the top level.
package lscd_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int FILL_W    = $clog2(NUM_SLOTS + 1);
    localparam int IDX_W     = 4;
    localparam int KEY_W     = 32;
    localparam int STAMP_W   = 32;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [FILL_W-1:0]  fill_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [STAMP_W-1:0] stamp_t;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_FREE   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/lscd_ctrl.sv @@
// Controller of the LRU slot cache directory: accept, scan, drain, update.
// Depends on lscd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lscd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lscd_pkg::dp_status_t  status,
    output lscd_pkg::ctrl_cmd_t   cmd
);

    lscd_pkg::state_t state_reg;
    lscd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lscd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            lscd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = lscd_pkg::ST_SCAN;
                end
            end
            lscd_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_last) begin
                    state_next = lscd_pkg::ST_DRAIN;
                end
            end
            lscd_pkg::ST_DRAIN: begin
                // hold until the result register can take the item
                if (status.out_free) begin
                    state_next = lscd_pkg::ST_UPDATE;
                end
            end
            lscd_pkg::ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = lscd_pkg::ST_IDLE;
            end
            default: begin
                state_next = lscd_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_update_out_free, cmd.update, status.out_free, "update while result busy")
    `ASSERT_NEXT(a_scan_to_drain, (state_reg == lscd_pkg::ST_SCAN) && status.scan_last,
                 state_reg == lscd_pkg::ST_DRAIN, "scan did not end in drain")

endmodule

@@ rtl/lscd_datapath.sv @@
// Datapath of the LRU slot cache directory: key and stamp memories, valid bits,
// serial match and minimum-stamp search, write-back and result register. Uses lscd_pkg.
`include "assert_macros.svh"

module lscd_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lscd_pkg::ctrl_cmd_t   cmd,
    output lscd_pkg::dp_status_t  status,
    input  logic                  s_kind,
    input  lscd_pkg::key_t        s_block_key,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lscd_pkg::idx_t        m_slot_index,
    output logic                  m_hit,
    output logic                  m_evicted_valid,
    output lscd_pkg::key_t        m_evicted_key
);

    localparam lscd_pkg::slot_t LAST_SLOT = lscd_pkg::slot_t'(lscd_pkg::NUM_SLOTS - 1);
    localparam lscd_pkg::fill_t FILL_MAX  = lscd_pkg::fill_t'(lscd_pkg::NUM_SLOTS);

    // storage
    lscd_pkg::key_t   key_mem   [lscd_pkg::NUM_SLOTS];
    lscd_pkg::stamp_t stamp_mem [lscd_pkg::NUM_SLOTS];
    logic [lscd_pkg::NUM_SLOTS-1:0] valid_reg;
    logic [lscd_pkg::NUM_SLOTS-1:0] stamp_wr_reg;
    lscd_pkg::stamp_t time_reg;
    lscd_pkg::fill_t  fill_reg;

    // item under work
    logic             kind_reg;
    lscd_pkg::key_t   key_reg;

    // scan pipeline
    lscd_pkg::slot_t  rd_addr_reg;
    logic             cmp_valid_reg;
    lscd_pkg::slot_t  cmp_idx_reg;
    lscd_pkg::key_t   key_rd_reg;
    lscd_pkg::stamp_t stamp_rd_reg;

    // search results
    logic             found_reg;
    lscd_pkg::slot_t  found_idx_reg;
    lscd_pkg::stamp_t min_stamp_reg;
    lscd_pkg::slot_t  min_idx_reg;
    lscd_pkg::key_t   min_key_reg;

    // result register
    logic             m_valid_reg;
    lscd_pkg::idx_t   slot_index_reg;
    logic             hit_reg;
    logic             ev_valid_reg;
    lscd_pkg::key_t   ev_key_reg;

    logic             is_free;
    logic             fill_open;
    lscd_pkg::slot_t  alloc_slot;
    lscd_pkg::slot_t  tgt_slot;
    lscd_pkg::stamp_t new_time;
    logic             ev_valid;
    logic             match;

    assign is_free    = (kind_reg == lscd_pkg::OP_FREE);
    assign fill_open  = (fill_reg < FILL_MAX);
    assign alloc_slot = fill_open ? lscd_pkg::slot_t'(fill_reg) : min_idx_reg;
    assign tgt_slot   = found_reg ? found_idx_reg : alloc_slot;
    assign new_time   = time_reg + lscd_pkg::stamp_t'(1);
    assign ev_valid   = !found_reg && valid_reg[alloc_slot];
    assign match      = valid_reg[cmp_idx_reg] && (key_rd_reg == key_reg);

    assign status.scan_last = (rd_addr_reg == LAST_SLOT);
    assign status.out_free  = !m_valid_reg || m_ready;

    // capture the item, walk the read address
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_kind;
            key_reg  <= s_block_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_addr_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            cmp_valid_reg <= cmd.scan;
            if (cmd.load) begin
                rd_addr_reg <= '0;
                found_reg   <= 1'b0;
            end else begin
                if (cmd.scan) begin
                    rd_addr_reg <= rd_addr_reg + lscd_pkg::slot_t'(1);
                end
                if (cmp_valid_reg && match) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // memory read port; an unwritten stamp reads as zero
    always_ff @(posedge aclk) begin
        cmp_idx_reg  <= rd_addr_reg;
        key_rd_reg   <= key_mem[rd_addr_reg];
        stamp_rd_reg <= stamp_wr_reg[rd_addr_reg] ? stamp_mem[rd_addr_reg] : '0;
    end

    // keep first match and lowest-index minimum stamp
    always_ff @(posedge aclk) begin
        if (cmp_valid_reg) begin
            if (match && !found_reg) begin
                found_idx_reg <= cmp_idx_reg;
            end
            if ((cmp_idx_reg == '0) || (stamp_rd_reg < min_stamp_reg)) begin
                min_stamp_reg <= stamp_rd_reg;
                min_idx_reg   <= cmp_idx_reg;
                min_key_reg   <= key_rd_reg;
            end
        end
    end

    // memory write port
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            if (is_free) begin
                if (found_reg) begin
                    stamp_mem[found_idx_reg] <= '0;
                end
            end else begin
                stamp_mem[tgt_slot] <= new_time;
                if (!found_reg) begin
                    key_mem[tgt_slot] <= key_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            stamp_wr_reg <= '0;
            time_reg     <= '0;
            fill_reg     <= '0;
        end else if (cmd.update) begin
            if (is_free) begin
                if (found_reg) begin
                    valid_reg[found_idx_reg]    <= 1'b0;
                    stamp_wr_reg[found_idx_reg] <= 1'b1;
                end
            end else begin
                time_reg               <= new_time;
                valid_reg[tgt_slot]    <= 1'b1;
                stamp_wr_reg[tgt_slot] <= 1'b1;
                if (!found_reg && fill_open) begin
                    fill_reg <= fill_reg + lscd_pkg::fill_t'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.update) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            hit_reg <= found_reg;
            if (is_free) begin
                slot_index_reg <= found_reg ? lscd_pkg::idx_t'(found_idx_reg) : '0;
                ev_valid_reg   <= 1'b0;
                ev_key_reg     <= '0;
            end else begin
                slot_index_reg <= lscd_pkg::idx_t'(tgt_slot);
                ev_valid_reg   <= ev_valid;
                ev_key_reg     <= ev_valid ? min_key_reg : '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_slot_index    = slot_index_reg;
    assign m_hit           = hit_reg;
    assign m_evicted_valid = ev_valid_reg;
    assign m_evicted_key   = ev_key_reg;

    `ASSERT_NEXT(a_lookup_binds_slot, cmd.update && !is_free,
                 valid_reg[$past(tgt_slot)], "looked-up slot not valid after update")
    `ASSERT_IMPL(a_found_is_valid, cmd.update && found_reg,
                 valid_reg[found_idx_reg], "matched slot not valid at update")

endmodule

@@ rtl/lru_slot_cache_directory_unit.sv @@
// LRU slot cache directory: 16 fully associative slots, timestamp replacement.
// Each item goes through accept, a scan of all 16 slots, drain and update;
// drain holds until the result register can take the result, and a new item
// is accepted only after update; the scan reads one slot per cycle via the key/stamp read port.
// Reset: synchronous active-low aresetn clears valid bits, stamps, time and
// fill pointer at once; no clearing pass, the key memory is not cleared.
module lru_slot_cache_directory_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  lscd_pkg::key_t       s_block_key,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lscd_pkg::idx_t       m_slot_index,
    output logic                 m_hit,
    output logic                 m_evicted_valid,
    output lscd_pkg::key_t       m_evicted_key
);

    lscd_pkg::ctrl_cmd_t  cmd;
    lscd_pkg::dp_status_t status;

    lscd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lscd_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_kind          (s_kind),
        .s_block_key     (s_block_key),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slot_index    (m_slot_index),
        .m_hit           (m_hit),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_key   (m_evicted_key)
    );

endmodule
